// File: sv/mtts_pkg.sv
// mtts_pkg: shared constants, register codes and helper functions for the
// morton tile texture swizzle block. No dependencies.
package mtts_pkg;

  // fixed field widths
  localparam int unsigned TEXEL_W   = 32;
  localparam int unsigned IDX_W     = 20;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // tile geometry: 8x8 tiles, 64 texels each
  localparam int unsigned TILE_DIM        = 8;
  localparam int unsigned TILE_SHIFT      = 3;
  localparam int unsigned TILE_AREA_SHIFT = 6;

  // queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 4;

  // dimension register reset values
  localparam int unsigned WIDTH_RESET  = 256;
  localparam int unsigned HEIGHT_RESET = 256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // zero reads as one, anything above max_dim reads as max_dim
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned max_dim);
    int unsigned vv;
    vv = 32'(v);
    if (vv == 0) begin
      return 1;
    end else if (vv > max_dim) begin
      return max_dim;
    end
    return vv;
  endfunction

  // z-order interleave inside a tile: x0 y0 x1 y1 x2 y2, x0 is the lsb
  function automatic logic [TILE_AREA_SHIFT-1:0] morton8(input logic [2:0] x,
                                                          input logic [2:0] y);
    return {y[2], x[2], y[1], x[1], y[0], x[0]};
  endfunction

endpackage

// File: sv/morton_tile_texture_swizzle.sv
// morton_tile_texture_swizzle: top level, dimension registers and the
// front / queue / back chain. Uses mtts_pkg, mtts_front, mtts_queue, mtts_back.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-------------------------------------
//   in_     | input     | in_valid/in_stall| in_texel_in
//   out_    | output    | out_valid/stall  | out_dest_index, out_texel_out,
//           |           |                  | out_frame_end
//   cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// one texel transfer per clock sustained while out_stall is low; a texel goes from
// its input to a queue slot, then via the index multiply into the output register
// the four-entry queue lets the front keep taking texels while the output
// register waits; in_stall rises only when that queue is full
// synchronous active-low reset clears counters, queue and output valid and
// loads 256x256 (clamped to MAX_DIM); no clearing pass, ready right away
module morton_tile_texture_swizzle #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mtts_pkg::TEXEL_W-1:0]        in_texel_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mtts_pkg::IDX_W-1:0]          out_dest_index,
  output logic [mtts_pkg::TEXEL_W-1:0]        out_texel_out,
  output logic                                out_frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mtts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtts_pkg::CFG_W-1:0]          cfg_data
);

  // counters hold 0..MAX_DIM-1, effective dimensions 1..MAX_DIM
  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned TPR_W = DIM_W - 2;
  localparam int unsigned Q_W   = mtts_pkg::TEXEL_W + 2 * CNT_W + 1;

  localparam int unsigned W_RST = (mtts_pkg::WIDTH_RESET > MAX_DIM) ?
                                  MAX_DIM : mtts_pkg::WIDTH_RESET;
  localparam int unsigned H_RST = (mtts_pkg::HEIGHT_RESET > MAX_DIM) ?
                                  MAX_DIM : mtts_pkg::HEIGHT_RESET;
  localparam int unsigned TPR_RST = (W_RST + mtts_pkg::TILE_DIM - 1) / mtts_pkg::TILE_DIM;

  // dimension registers hold the clamped value so no clamp sits in the data path
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [TPR_W-1:0] tpr_r, tpr_nxt;
  logic [DIM_W-1:0] dim_clamped;
  logic [DIM_W:0]   width_round;
  logic             cfg_write;
  logic             cfg_clear;

  logic                          push, pop, q_full, q_not_empty;
  logic [mtts_pkg::TEXEL_W-1:0]  push_texel;
  logic [CNT_W-1:0]              push_x, push_y;
  logic                          push_last;
  logic [Q_W-1:0]                head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    dim_clamped = DIM_W'(mtts_pkg::clamp_dim(cfg_data, MAX_DIM));
    width_round = {1'b0, dim_clamped} + (DIM_W + 1)'(mtts_pkg::TILE_DIM - 1);
    width_nxt   = width_r;
    height_nxt  = height_r;
    tpr_nxt     = tpr_r;
    cfg_clear   = 1'b0;
    if (cfg_write) begin
      case (cfg_index)
        mtts_pkg::REG_IMAGE_WIDTH: begin
          width_nxt = dim_clamped;
          tpr_nxt   = TPR_W'(width_round >> mtts_pkg::TILE_SHIFT);
          cfg_clear = 1'b1;
        end
        mtts_pkg::REG_IMAGE_HEIGHT: begin
          height_nxt = dim_clamped;
          cfg_clear  = 1'b1;
        end
        default: begin
          // unknown register: ignored, counters kept
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(W_RST);
      height_r <= DIM_W'(H_RST);
      tpr_r    <= TPR_W'(TPR_RST);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      tpr_r    <= tpr_nxt;
    end
  end

  mtts_front #(
    .CNT_W (CNT_W),
    .DIM_W (DIM_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_texel   (in_texel_in),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .cfg_clear  (cfg_clear),
    .width_eff  (width_r),
    .height_eff (height_r),
    .push       (push),
    .push_texel (push_texel),
    .push_x     (push_x),
    .push_y     (push_y),
    .push_last  (push_last)
  );

  mtts_queue #(
    .WIDTH (Q_W),
    .DEPTH (mtts_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_texel, push_x, push_y, push_last}),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_data (head)
  );

  mtts_back #(
    .CNT_W (CNT_W),
    .TPR_W (TPR_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_texel        (head[Q_W-1 -: mtts_pkg::TEXEL_W]),
    .q_x            (head[2*CNT_W -: CNT_W]),
    .q_y            (head[CNT_W -: CNT_W]),
    .q_last         (head[0]),
    .pop            (pop),
    .tiles_per_row  (tpr_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dest_index (out_dest_index),
    .out_texel_out  (out_texel_out),
    .out_frame_end  (out_frame_end)
  );

endmodule

// File: sv/mtts_front.sv
// mtts_front: takes texels, tracks column and source row, works out the
// image row and the last-texel flag. Uses mtts_pkg.
module mtts_front #(
  parameter int unsigned CNT_W = 10,
  parameter int unsigned DIM_W = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [mtts_pkg::TEXEL_W-1:0]      in_texel,
  output logic                              in_stall,
  input  logic                              q_full,
  input  logic                              cfg_clear,
  input  logic [DIM_W-1:0]                  width_eff,
  input  logic [DIM_W-1:0]                  height_eff,
  output logic                              push,
  output logic [mtts_pkg::TEXEL_W-1:0]      push_texel,
  output logic [CNT_W-1:0]                  push_x,
  output logic [CNT_W-1:0]                  push_y,
  output logic                              push_last
);

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_inc, row_inc, y_full;
  logic             last_col, last_row;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    col_inc  = DIM_W'(col_r) + DIM_W'(1);
    row_inc  = DIM_W'(row_r) + DIM_W'(1);
    last_col = col_inc >= width_eff;
    last_row = row_inc >= height_eff;
    // vertical flip: source row r lands on image row height-1-r
    y_full   = height_eff - row_inc;

    push_texel = in_texel;
    push_x     = col_r;
    push_y     = CNT_W'(y_full);
    push_last  = last_col && last_row;

    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (push) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : CNT_W'(row_inc);
      end else begin
        col_nxt = CNT_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: sv/mtts_queue.sv
// mtts_queue: small first-in first-out buffer between the front and the
// back. Uses no package; its width and depth come from the caller.
module mtts_queue #(
  parameter int unsigned WIDTH = 53,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/mtts_back.sv
// mtts_back: builds the tiled destination index from column and image row
// and holds the result in the output register. Uses mtts_pkg.
module mtts_back #(
  parameter int unsigned CNT_W = 10,
  parameter int unsigned TPR_W = 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  input  logic [mtts_pkg::TEXEL_W-1:0]      q_texel,
  input  logic [CNT_W-1:0]                  q_x,
  input  logic [CNT_W-1:0]                  q_y,
  input  logic                              q_last,
  output logic                              pop,
  input  logic [TPR_W-1:0]                  tiles_per_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mtts_pkg::IDX_W-1:0]        out_dest_index,
  output logic [mtts_pkg::TEXEL_W-1:0]      out_texel_out,
  output logic                              out_frame_end
);

  localparam int unsigned PROD_W = CNT_W + TPR_W;
  localparam int unsigned TILE_W = PROD_W + 1;
  localparam int unsigned FULL_W = TILE_W + mtts_pkg::TILE_AREA_SHIFT;
  localparam int unsigned SUM_W  = (FULL_W > mtts_pkg::IDX_W) ? FULL_W : mtts_pkg::IDX_W;

  logic                               valid_r, valid_nxt;
  logic [mtts_pkg::IDX_W-1:0]         index_r;
  logic [mtts_pkg::TEXEL_W-1:0]       texel_r;
  logic                               last_r;
  logic [CNT_W-1:0]                   tile_row, tile_col;
  logic [PROD_W-1:0]                  row_base;
  logic [TILE_W-1:0]                  tile_num;
  logic [mtts_pkg::TILE_AREA_SHIFT-1:0] z_off;
  logic [SUM_W-1:0]                   index_full;

  // refill the output register when it is empty or being taken
  assign pop = q_not_empty && (!valid_r || !out_stall);

  always_comb begin
    tile_row   = q_y >> mtts_pkg::TILE_SHIFT;
    tile_col   = q_x >> mtts_pkg::TILE_SHIFT;
    row_base   = PROD_W'(tile_row) * PROD_W'(tiles_per_row);
    tile_num   = TILE_W'(row_base) + TILE_W'(tile_col);
    z_off      = mtts_pkg::morton8(q_x[2:0], q_y[2:0]);
    index_full = SUM_W'({tile_num, z_off});

    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      index_r <= index_full[mtts_pkg::IDX_W-1:0];
      texel_r <= q_texel;
      last_r  <= q_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_dest_index = index_r;
  assign out_texel_out  = texel_r;
  assign out_frame_end  = last_r;

endmodule

// File: sv/mtts_checker.sv
// mtts_checker: port-level checks on the swizzle top level, bound to it
// below. Uses no package.
module mtts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [19:0] out_dest_index,
  input logic [31:0] out_texel_out,
  input logic        out_frame_end
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_dest_index) && $stable(out_texel_out)
                               && $stable(out_frame_end))
    else $error("result payload changed while stalled");

  // an idle output only wakes up for a texel taken at the input and passed
  // through a queue slot, then the output register
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared with no texel behind it");

  // reset empties the pipe and opens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state left over after reset");

endmodule

bind morton_tile_texture_swizzle mtts_checker u_mtts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_dest_index (out_dest_index),
  .out_texel_out  (out_texel_out),
  .out_frame_end  (out_frame_end)
);
